// File: rtl/sae_pkg.sv
// ----------------------------------------------------------------------------
// sae_pkg: shared constants for the suffix automaton extend block
// Default store sizes and the fixed widths of the item fields.
// ----------------------------------------------------------------------------
package sae_pkg;

  localparam int SAE_MAX_STATES = 4096;
  localparam int SAE_ALPHABET   = 26;

  localparam int SYMBOL_W = 5;
  localparam int STATE_W  = 12;
  localparam int COUNT_W  = 24;

endpackage

// File: rtl/sae_engine.sv
// ----------------------------------------------------------------------------
// sae_engine: sequencer and stores for one suffix automaton extension
// Holds the transition, link and length memories and walks them for one item
// at a time; the transition memory uses a single shared row-address unit.
// ----------------------------------------------------------------------------
module sae_engine #(
  parameter int MAX_STATES = sae_pkg::SAE_MAX_STATES,
  parameter int ALPHABET   = sae_pkg::SAE_ALPHABET
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         idle,
  input  logic [sae_pkg::SYMBOL_W-1:0] symbol,
  input  logic                         restart,
  input  logic [sae_pkg::STATE_W-1:0]  start_state,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic [sae_pkg::STATE_W-1:0]  res_new_last,
  output logic [sae_pkg::STATE_W-1:0]  res_state_count,
  output logic [sae_pkg::COUNT_W-1:0]  res_distinct,
  output logic                         res_overflow
);

  localparam int SW    = $clog2(MAX_STATES);
  localparam int XW    = (SW > sae_pkg::STATE_W) ? SW : sae_pkg::STATE_W;
  localparam int DEPTH = MAX_STATES * ALPHABET;
  localparam int AW    = $clog2(DEPTH);
  localparam int CLW   = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
  localparam int GW    = SW + 1;
  localparam logic [AW-1:0]  ALPHA_AW = AW'(ALPHABET);
  localparam logic [CLW-1:0] COL_LAST = CLW'(ALPHABET - 1);
  localparam logic [SW-1:0]  ROOT     = SW'(1);
  localparam logic [GW-1:0]  GUARD_MAX = GW'(MAX_STATES);

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_CLR, S_LEN_RD, S_LEN_WR, S_W1_RD, S_W1_CHK,
    S_Q_RD, S_Q_LQ, S_Q_CMP, S_CP, S_CL_RD, S_CL_NQ, S_CL_Q, S_CL_NP,
    S_W2_RD, S_W2_CHK, S_LNK_WR, S_FIN_RD, S_FIN, S_DONE
  } state_t;

  state_t state;

  logic [SW-1:0] trans_mem [DEPTH];
  logic [SW-1:0] link_mem  [MAX_STATES];
  logic [SW-1:0] len_mem   [MAX_STATES];

  logic [SW-1:0] last, top, p, np, q, nq, lnk, lenp, lennp;
  logic [sae_pkg::SYMBOL_W-1:0] sym;
  logic [sae_pkg::COUNT_W-1:0]  total;
  logic [CLW-1:0] col;
  logic           phase;
  logic [GW-1:0]  guard;
  logic           ovf;

  logic [SW-1:0] row_sel;
  logic [AW-1:0] col_sel, t_addr;
  logic          t_we, l_we, n_we;
  logic [SW-1:0] t_wdata, t_rdata;
  logic [SW-1:0] l_waddr, l_wdata, l_raddr, l_rdata;
  logic [SW-1:0] n_waddr, n_wdata, n_raddr, n_rdata;

  logic          bad_item;
  logic [XW-1:0] sel_ext;
  logic [SW-1:0] lennp_c;

  assign t_addr  = AW'(row_sel) * ALPHA_AW + col_sel;
  assign lennp_c = ((p == '0) ? '0 : n_rdata) + SW'(1);

  assign bad_item = (32'(symbol) >= 32'(ALPHABET)) ||
                    ((GW'(top) + GW'(2)) >= GUARD_MAX);
  assign sel_ext  = restart ? XW'(start_state) : XW'(last);

  always_ff @(posedge clk) begin
    if (t_we) trans_mem[t_addr] <= t_wdata;
    t_rdata <= trans_mem[t_addr];
    if (l_we) link_mem[l_waddr] <= l_wdata;
    l_rdata <= link_mem[l_raddr];
    if (n_we) len_mem[n_waddr] <= n_wdata;
    n_rdata <= len_mem[n_raddr];
  end

  always_comb begin
    row_sel = '0;
    col_sel = AW'(col);
    t_we    = 1'b0;
    t_wdata = '0;
    l_we    = 1'b0;
    l_waddr = '0;
    l_wdata = '0;
    l_raddr = '0;
    n_we    = 1'b0;
    n_waddr = '0;
    n_wdata = '0;
    n_raddr = '0;
    case (state)
      S_INIT: begin
        row_sel = ROOT;
        t_we    = 1'b1;
        l_we    = 1'b1;
        l_waddr = ROOT;
        n_we    = 1'b1;
        n_waddr = ROOT;
      end
      S_CLR: begin
        row_sel = np;
        t_we    = 1'b1;
      end
      S_LEN_RD: n_raddr = p;
      S_LEN_WR: begin
        n_we    = 1'b1;
        n_waddr = np;
        n_wdata = lennp_c;
      end
      S_W1_RD, S_W2_RD: begin
        row_sel = p;
        col_sel = AW'(sym);
        l_raddr = p;
      end
      S_W1_CHK: begin
        row_sel = p;
        col_sel = AW'(sym);
        t_we    = (t_rdata == '0);
        t_wdata = np;
      end
      S_W2_CHK: begin
        row_sel = p;
        col_sel = AW'(sym);
        t_we    = (t_rdata == q);
        t_wdata = nq;
      end
      S_Q_RD: n_raddr = p;
      S_Q_LQ: n_raddr = q;
      S_CP: begin
        // read the source entry, then write it to the clone's row
        row_sel = phase ? nq : q;
        t_we    = phase;
        t_wdata = t_rdata;
      end
      S_CL_RD: l_raddr = q;
      S_CL_NQ: begin
        l_we    = 1'b1;
        l_waddr = nq;
        l_wdata = l_rdata;
        n_we    = 1'b1;
        n_waddr = nq;
        n_wdata = lenp + SW'(1);
      end
      S_CL_Q: begin
        l_we    = 1'b1;
        l_waddr = q;
        l_wdata = nq;
      end
      S_CL_NP: begin
        l_we    = 1'b1;
        l_waddr = np;
        l_wdata = nq;
      end
      S_LNK_WR: begin
        l_we    = 1'b1;
        l_waddr = np;
        l_wdata = lnk;
      end
      S_FIN_RD: n_raddr = lnk;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      last  <= ROOT;
      top   <= ROOT;
      total <= '0;
      col   <= '0;
      phase <= 1'b0;
      guard <= '0;
      ovf   <= 1'b0;
    end else begin
      case (state)
        S_INIT: begin
          col <= col + CLW'(1);
          if (col == COL_LAST) begin
            col   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            sym <= symbol;
            if (bad_item) begin
              ovf   <= 1'b1;
              state <= S_DONE;
            end else begin
              ovf   <= 1'b0;
              p     <= (sel_ext > XW'(top)) ? '0 : SW'(sel_ext);
              np    <= top + SW'(1);
              top   <= top + SW'(1);
              col   <= '0;
              guard <= '0;
              state <= S_CLR;
            end
          end
        end
        S_CLR: begin
          col <= col + CLW'(1);
          if (col == COL_LAST) begin
            col   <= '0;
            state <= S_LEN_RD;
          end
        end
        S_LEN_RD: state <= S_LEN_WR;
        S_LEN_WR: begin
          lennp <= lennp_c;
          state <= S_W1_RD;
        end
        S_W1_RD: begin
          if (p == '0 || guard >= GUARD_MAX) begin
            lnk   <= ROOT;
            state <= S_LNK_WR;
          end else begin
            state <= S_W1_CHK;
          end
        end
        S_W1_CHK: begin
          if (t_rdata == '0) begin
            p     <= l_rdata;
            guard <= guard + GW'(1);
            state <= S_W1_RD;
          end else begin
            q     <= t_rdata;
            state <= S_Q_RD;
          end
        end
        S_Q_RD: state <= S_Q_LQ;
        S_Q_LQ: begin
          lenp  <= n_rdata;
          state <= S_Q_CMP;
        end
        S_Q_CMP: begin
          if (n_rdata == lenp + SW'(1)) begin
            lnk   <= q;
            state <= S_LNK_WR;
          end else begin
            nq    <= top + SW'(1);
            top   <= top + SW'(1);
            col   <= '0;
            phase <= 1'b0;
            state <= S_CP;
          end
        end
        S_CP: begin
          phase <= ~phase;
          if (phase) begin
            col <= col + CLW'(1);
            if (col == COL_LAST) begin
              col   <= '0;
              state <= S_CL_RD;
            end
          end
        end
        S_CL_RD: state <= S_CL_NQ;
        S_CL_NQ: state <= S_CL_Q;
        S_CL_Q: begin
          lnk   <= nq;
          guard <= '0;
          state <= S_CL_NP;
        end
        S_CL_NP: state <= S_W2_RD;
        S_W2_RD: begin
          if (p == '0 || guard >= GUARD_MAX) state <= S_FIN_RD;
          else state <= S_W2_CHK;
        end
        S_W2_CHK: begin
          if (t_rdata == q) begin
            p     <= l_rdata;
            guard <= guard + GW'(1);
            state <= S_W2_RD;
          end else begin
            state <= S_FIN_RD;
          end
        end
        S_LNK_WR: state <= S_FIN_RD;
        S_FIN_RD: state <= S_FIN;
        S_FIN: begin
          total <= total + sae_pkg::COUNT_W'(lennp) - sae_pkg::COUNT_W'(n_rdata);
          last  <= np;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) state <= S_IDLE;
        end
        default: state <= S_INIT;
      endcase
    end
  end

  assign idle            = (state == S_IDLE);
  assign res_valid       = (state == S_DONE);
  assign res_new_last    = sae_pkg::STATE_W'(last);
  assign res_state_count = sae_pkg::STATE_W'(top);
  assign res_distinct    = total;
  assign res_overflow    = ovf;

endmodule

// File: rtl/suffix_automaton_extend_top.sv
// An item clears its new row and walks suffix links; a clone also copies a
// row and redirects transitions. Rejected items go straight to the result.
// One item at a time; the single transition memory port sets the rate (row
// clear and row copy dominate). After reset the root row is cleared before
// the first item is accepted; the output register holds a finished result
// while a new item runs.
// ----------------------------------------------------------------------------
// suffix_automaton_extend_top: online suffix automaton, one symbol per item
// Input handshake, extension engine and a registered output stage.
// ----------------------------------------------------------------------------
module suffix_automaton_extend_top #(
  parameter int MAX_STATES = sae_pkg::SAE_MAX_STATES,
  parameter int ALPHABET   = sae_pkg::SAE_ALPHABET
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sae_pkg::SYMBOL_W-1:0] symbol,
  input  logic                         restart,
  input  logic [sae_pkg::STATE_W-1:0]  start_state,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sae_pkg::STATE_W-1:0]  new_last,
  output logic [sae_pkg::STATE_W-1:0]  state_count,
  output logic [sae_pkg::COUNT_W-1:0]  distinct_count,
  output logic                         overflow
);

  logic                        eng_idle, res_valid, res_ready;
  logic [sae_pkg::STATE_W-1:0] res_new_last, res_state_count;
  logic [sae_pkg::COUNT_W-1:0] res_distinct;
  logic                        res_overflow;

  sae_engine #(
    .MAX_STATES (MAX_STATES),
    .ALPHABET   (ALPHABET)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .start           (in_valid),
    .idle            (eng_idle),
    .symbol          (symbol),
    .restart         (restart),
    .start_state     (start_state),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res_new_last    (res_new_last),
    .res_state_count (res_state_count),
    .res_distinct    (res_distinct),
    .res_overflow    (res_overflow)
  );

  assign in_ready  = eng_idle;
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (res_ready) out_valid <= res_valid;
    end
  end

  // load the output stage on each engine transfer
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      new_last       <= res_new_last;
      state_count    <= res_state_count;
      distinct_count <= res_distinct;
      overflow       <= res_overflow;
    end
  end

endmodule
